// File: rtl/aitr_pkg.sv
// Shared types and constants for the aging identifier table.
`timescale 1ns / 1ps

package aitr_pkg;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_RECEIVE = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_NEXT    = 2'd2,
		OP_TICK    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_SWEEP,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  stone_id;
		logic [63:0] payload;
		logic [31:0] tick_count;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  found_id;
		logic [63:0] found_payload;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] count;
		logic [63:0] payload;
	} entry_t;

	typedef struct packed {
		logic done;
		logic zero;
	} div_stat_t;

endpackage

// File: rtl/aitr_tick_div.sv
// Remainder test that tells whether a tick number is a multiple of the divider.
`timescale 1ns / 1ps

module aitr_tick_div #(
	parameter int DIV = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         value,
	output aitr_pkg::div_stat_t stat
);

	localparam int          SH    = 20 + $clog2(DIV);
	localparam logic [9:0]  DIV_C = 10'(DIV);
	localparam logic [9:0]  K0    = 10'(1 % DIV);
	localparam logic [9:0]  K1    = 10'(256 % DIV);
	localparam logic [9:0]  K2    = 10'(65536 % DIV);
	localparam logic [9:0]  K3    = 10'(16777216 % DIV);
	localparam logic [20:0] RECIP =
		21'(((longint'(1) << SH) + longint'(DIV) - longint'(1)) / longint'(DIV));

	logic [2:0]  stg_q;
	logic        done_q;
	logic [31:0] val_q;
	logic [19:0] fold_s1;
	logic [19:0] fold_s2;
	logic [19:0] quo_s2;
	logic        zero_q;
	logic [19:0] fold;
	logic [40:0] prod;
	logic [29:0] back;

	// The bytes weighted by their residues keep the residue of the tick number in 20 bits.
	// A reciprocal multiplication gives the quotient of that sum, and the sum is a multiple
	// exactly when the quotient times the divider gives it back.
	always_comb begin
		fold = 20'(val_q[7:0]) * 20'(K0) + 20'(val_q[15:8]) * 20'(K1) +
		       20'(val_q[23:16]) * 20'(K2) + 20'(val_q[31:24]) * 20'(K3);
		prod = 41'(fold_s1) * 41'(RECIP);
		back = 30'(quo_s2) * 30'(DIV_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q  <= '0;
			done_q <= 1'b0;
		end else begin
			stg_q  <= {stg_q[1:0], start};
			done_q <= stg_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
		end
		if (stg_q[0]) begin
			fold_s1 <= fold;
		end
		if (stg_q[1]) begin
			quo_s2  <= 20'(prod >> SH);
			fold_s2 <= fold_s1;
		end
		if (stg_q[2]) begin
			zero_q <= (back == 30'(fold_s2));
		end
	end

	assign stat.done = done_q;
	assign stat.zero = zero_q;

endmodule

// File: rtl/aging_id_table_round_robin_core.sv
// Top level of the aging identifier table with round-robin readout.
`timescale 1ns / 1ps

// The table lives in one single-port-read memory of ENTRIES words; receive, remove and next
// items and aging sweeps walk it one entry per cycle. Receive, remove and next items pass
// through ENTRIES reads, the read register, a step that closes the scan, a write-back state and
// a result state. A tick item first tests its tick number against TICKS_PER_DECREMENT in the
// divider; off the divider its result follows, on the divider an aging sweep of ENTRIES reads
// comes first. One item is worked on at a time and the input stalls until its result is loaded;
// the next item is taken the cycle after that, even while the previous result waits to be taken.
// Reset clears the table at once through per-entry valid bits, so no clearing pass is needed.
module aging_id_table_round_robin_core #(
	parameter int ENTRIES             = 8,
	parameter int TICKS_PER_DECREMENT = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_data,
	input  logic           req_valid,
	output logic           req_stall,
	input  aitr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output aitr_pkg::rsp_t rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
		if (idx == IW'(ENTRIES - 1)) begin
			return '0;
		end
		return idx + IW'(1);
	endfunction

	aitr_pkg::state_t    state_q;
	aitr_pkg::state_t    state_nx;
	aitr_pkg::req_t      op_q;
	aitr_pkg::entry_t    mem [ENTRIES];
	aitr_pkg::entry_t    rd_ent_s1;
	aitr_pkg::entry_t    ent;
	aitr_pkg::entry_t    mem_wdata;
	aitr_pkg::rsp_t      rsp_q;
	aitr_pkg::div_stat_t div_stat;

	logic [ENTRIES-1:0] valid_q;
	logic [15:0]        tstart_q;
	logic [IW-1:0]      next_pick_q;
	logic [IW-1:0]      rd_addr_q;
	logic [CW-1:0]      issued_q;
	logic               chk_s1;
	logic [IW-1:0]      slot_s1;
	logic               rd_vld_s1;
	logic               hit_q;
	logic [IW-1:0]      hit_slot_q;
	logic [63:0]        hit_pay_q;
	logic [15:0]        low_cnt_q;
	logic [IW-1:0]      low_slot_q;
	logic               live_q;
	logic [IW-1:0]      live_slot_q;
	logic [7:0]         live_id_q;
	logic [63:0]        live_pay_q;
	logic               rsp_valid_q;

	logic          accept;
	logic          issue;
	logic          scan_end;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic          load_rsp;
	logic          div_start;

	aitr_tick_div #(
		.DIV(TICKS_PER_DECREMENT)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.value (req.tick_count),
		.stat  (div_stat)
	);

	assign ent      = rd_vld_s1 ? rd_ent_s1 : '0;
	assign issue    = (state_q == aitr_pkg::ST_SCAN || state_q == aitr_pkg::ST_SWEEP) &&
	                  (issued_q != CW'(ENTRIES));
	assign scan_end = (issued_q == CW'(ENTRIES)) && !chk_s1;
	assign accept   = req_valid && (state_q == aitr_pkg::ST_IDLE);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			aitr_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req.opcode == aitr_pkg::OP_TICK) begin
						state_nx = aitr_pkg::ST_MOD;
					end else begin
						state_nx = aitr_pkg::ST_SCAN;
					end
				end
			end
			aitr_pkg::ST_MOD: begin
				if (div_stat.done) begin
					state_nx = div_stat.zero ? aitr_pkg::ST_SWEEP : aitr_pkg::ST_DONE;
				end
			end
			aitr_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_nx = aitr_pkg::ST_WRITE;
				end
			end
			aitr_pkg::ST_SWEEP: begin
				if (scan_end) begin
					state_nx = aitr_pkg::ST_DONE;
				end
			end
			aitr_pkg::ST_WRITE: begin
				state_nx = aitr_pkg::ST_DONE;
			end
			aitr_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_nx = aitr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = aitr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_s1;
		mem_wdata = ent;
		load_rsp  = 1'b0;
		div_start = accept && (req.opcode == aitr_pkg::OP_TICK);
		req_stall = (state_q != aitr_pkg::ST_IDLE);
		case (state_q)
			aitr_pkg::ST_SWEEP: begin
				mem_we = chk_s1;
				if (ent.count != 16'd0) begin
					mem_wdata.count = ent.count - 16'd1;
				end
			end
			aitr_pkg::ST_WRITE: begin
				if (op_q.opcode == aitr_pkg::OP_RECEIVE) begin
					mem_we            = 1'b1;
					mem_waddr         = hit_q ? hit_slot_q : low_slot_q;
					mem_wdata.id      = op_q.stone_id;
					mem_wdata.count   = tstart_q;
					mem_wdata.payload = op_q.payload;
				end else if (op_q.opcode == aitr_pkg::OP_REMOVE) begin
					mem_we            = hit_q;
					mem_waddr         = hit_slot_q;
					mem_wdata.id      = op_q.stone_id;
					mem_wdata.count   = 16'd0;
					mem_wdata.payload = hit_pay_q;
				end
			end
			aitr_pkg::ST_DONE: begin
				load_rsp = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aitr_pkg::ST_IDLE;
			tstart_q    <= 16'd60;
			valid_q     <= '0;
			next_pick_q <= '0;
			chk_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			chk_s1  <= issue;
			if (cfg_we) begin
				tstart_q <= cfg_data;
			end
			if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end
			if (state_q == aitr_pkg::ST_WRITE && op_q.opcode == aitr_pkg::OP_NEXT && live_q) begin
				next_pick_q <= wrap_inc(live_slot_q);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_ent_s1 <= mem[rd_addr_q];
		rd_vld_s1 <= valid_q[rd_addr_q];
		slot_s1   <= rd_addr_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req;
			rd_addr_q  <= (req.opcode == aitr_pkg::OP_NEXT) ? next_pick_q : '0;
			issued_q   <= '0;
			hit_q      <= 1'b0;
			low_cnt_q  <= aitr_pkg::COUNT_MAX;
			low_slot_q <= '0;
			live_q     <= 1'b0;
		end else begin
			if (issue) begin
				rd_addr_q <= wrap_inc(rd_addr_q);
				issued_q  <= issued_q + CW'(1);
			end
			if (state_q == aitr_pkg::ST_SCAN && chk_s1) begin
				if (ent.id == op_q.stone_id && !hit_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= slot_s1;
					hit_pay_q  <= ent.payload;
				end
				if (ent.count < low_cnt_q) begin
					low_cnt_q  <= ent.count;
					low_slot_q <= slot_s1;
				end
				if (ent.count != 16'd0 && !live_q) begin
					live_q      <= 1'b1;
					live_slot_q <= slot_s1;
					live_id_q   <= ent.id;
					live_pay_q  <= ent.payload;
				end
			end
		end
		if (load_rsp) begin
			if (op_q.opcode == aitr_pkg::OP_NEXT && live_q) begin
				rsp_q.found         <= 1'b1;
				rsp_q.found_id      <= live_id_q;
				rsp_q.found_payload <= live_pay_q;
			end else begin
				rsp_q <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/aitr_checker.sv
// Port-level assertions for the aging identifier table and their binding to the top level.
`timescale 1ns / 1ps

module aitr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input aitr_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result item changed or vanished.");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.found_id == 8'd0 && rsp.found_payload == 64'd0)
		else $error("Result item without a hit carries nonzero fields.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("A second item was taken while the first was still in work.");

endmodule

bind aging_id_table_round_robin_core aitr_checker u_aitr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

// File: test/aitr_table_checker.sv
// Checker that predicts every table result from the accepted items and compares it.
`timescale 1ns / 1ps

module aitr_table_checker #(
	parameter int ENTRIES             = 8,
	parameter int TICKS_PER_DECREMENT = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_data,
	input  logic           req_valid,
	input  logic           req_stall,
	input  aitr_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  aitr_pkg::rsp_t rsp,
	output int             errors,
	output int             pending
);

	localparam logic [15:0] START_AT_RESET = 16'd60;

	logic [7:0]     slot_ids[ENTRIES];
	logic [15:0]    slot_counts[ENTRIES];
	logic [63:0]    slot_payloads[ENTRIES];
	int             search_from;
	logic [15:0]    load_count;
	aitr_pkg::rsp_t owed_results[$];

	initial errors = 0;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		errors++;
	endtask

	// Applies one item to the shadow table and returns the result it must produce.
	function automatic aitr_pkg::rsp_t apply_to_table(input aitr_pkg::req_t item);
		aitr_pkg::rsp_t result;
		int             i;
		int             slot;
		int             low_slot;
		logic [15:0]    low_count;
		result = '0;
		slot = -1;
		case (aitr_pkg::opcode_t'(item.opcode))
			aitr_pkg::OP_RECEIVE: begin
				for (i = 0; i < ENTRIES; i++)
					if (slot < 0 && slot_ids[i] == item.stone_id)
						slot = i;
				if (slot < 0) begin
					low_slot = 0;
					low_count = aitr_pkg::COUNT_MAX;
					for (i = 0; i < ENTRIES; i++)
						if (slot_counts[i] < low_count) begin
							low_count = slot_counts[i];
							low_slot = i;
						end
					slot = low_slot;
				end
				slot_ids[slot] = item.stone_id;
				slot_counts[slot] = load_count;
				slot_payloads[slot] = item.payload;
			end
			aitr_pkg::OP_REMOVE: begin
				for (i = 0; i < ENTRIES; i++)
					if (slot < 0 && slot_ids[i] == item.stone_id)
						slot = i;
				if (slot >= 0)
					slot_counts[slot] = '0;
			end
			aitr_pkg::OP_NEXT: begin
				for (i = 0; i < ENTRIES; i++)
					if (slot < 0 && slot_counts[(search_from + i) % ENTRIES] != 0)
						slot = (search_from + i) % ENTRIES;
				if (slot >= 0) begin
					search_from = (slot + 1) % ENTRIES;
					result.found = 1'b1;
					result.found_id = slot_ids[slot];
					result.found_payload = slot_payloads[slot];
				end
			end
			default: begin
				if (item.tick_count % TICKS_PER_DECREMENT == 0)
					for (i = 0; i < ENTRIES; i++)
						if (slot_counts[i] != 0)
							slot_counts[i] = slot_counts[i] - 16'd1;
			end
		endcase
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		aitr_pkg::rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_ids[i] = '0;
				slot_counts[i] = '0;
				slot_payloads[i] = '0;
			end
			search_from = 0;
			load_count = START_AT_RESET;
			owed_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				load_count = cfg_data;
			if (req_valid && !req_stall)
				owed_results.push_back(apply_to_table(req));
			if (rsp_valid && !rsp_stall) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result arrived with no item outstanding");
				end else begin
					want = owed_results.pop_front();
					if (rsp.found !== want.found)
						report_mismatch($sformatf("found: expected %0d, got %0d",
							want.found, rsp.found));
					if (rsp.found_id !== want.found_id)
						report_mismatch($sformatf("found_id: expected %02h, got %02h",
							want.found_id, rsp.found_id));
					if (rsp.found_payload !== want.found_payload)
						report_mismatch($sformatf("found_payload: expected %016h, got %016h",
							want.found_payload, rsp.found_payload));
				end
			end
			pending <= owed_results.size();
		end
	end

endmodule

// File: test/tb.sv
// Testbench top for the aging identifier table: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

	typedef enum int {
		PH_FREE,
		PH_SRC_IDLE,
		PH_SNK_STALL,
		PH_BOTH
	} idle_mode_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [15:0]    cfg_data;
	logic           req_valid;
	logic           req_stall;
	aitr_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	aitr_pkg::rsp_t rsp;
	int             errors;
	int             pending;

	idle_mode_t  phase = PH_FREE;
	bit          long_hold_go = 1'b0;
	logic [31:0] tick_no = 32'd0;

	aging_id_table_round_robin_core #(
		.ENTRIES(8),
		.TICKS_PER_DECREMENT(10)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	aitr_table_checker #(
		.ENTRIES(8),
		.TICKS_PER_DECREMENT(10)
	) table_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bit sender_idles();
		case (phase)
			PH_SRC_IDLE: return $urandom_range(0, 99) < 88;
			PH_BOTH:     return $urandom_range(0, 99) < 23;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (phase)
			PH_SNK_STALL: return $urandom_range(0, 99) < 88;
			PH_BOTH:      return $urandom_range(0, 99) < 23;
			default:      return 1'b0;
		endcase
	endfunction

	// The receiver can also hold off for a long stretch so that the table stalls its input.
	initial begin
		int held;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_go) begin
				long_hold_go = 1'b0;
				held = 0;
				while (held < 300) begin
					rsp_stall <= 1'b1;
					@(posedge clk);
					held++;
				end
			end
			rsp_stall <= receiver_stalls();
		end
	end

	function automatic aitr_pkg::req_t make_item(input aitr_pkg::opcode_t op,
		input logic [7:0] id, input logic [63:0] word, input logic [31:0] tick);
		aitr_pkg::req_t item;
		item.opcode = op;
		item.stone_id = id;
		item.payload = word;
		item.tick_count = tick;
		return item;
	endfunction

	// Identifiers mostly come from a small pool so that receives and removes find matches.
	function automatic aitr_pkg::req_t random_item();
		aitr_pkg::req_t item;
		int unsigned    op_draw;
		int unsigned    id_draw;
		op_draw = $urandom_range(0, 99);
		id_draw = $urandom_range(0, 15);
		item.payload = {$urandom, $urandom};
		if (op_draw < 35)
			item.opcode = aitr_pkg::OP_RECEIVE;
		else if (op_draw < 50)
			item.opcode = aitr_pkg::OP_REMOVE;
		else if (op_draw < 80)
			item.opcode = aitr_pkg::OP_NEXT;
		else
			item.opcode = aitr_pkg::OP_TICK;
		if (id_draw == 11)
			item.stone_id = 8'hFF;
		else if (id_draw < 11)
			item.stone_id = 8'(id_draw * 21);
		else
			item.stone_id = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: item.tick_count = $urandom;
			1: item.tick_count = ($urandom / 10) * 10;
			default: begin
				item.tick_count = tick_no;
				tick_no = tick_no + 32'd1;
			end
		endcase
		return item;
	endfunction

	task automatic send(input aitr_pkg::req_t item);
		while (sender_idles()) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
	endtask

	task automatic write_start(input logic [15:0] value);
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int          round;
		int          k;
		logic [15:0] start_value;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(make_item(aitr_pkg::OP_NEXT, 8'h00, 64'h0, 32'h0));
		send(make_item(aitr_pkg::OP_REMOVE, 8'h05, 64'h0, 32'h0));
		send(make_item(aitr_pkg::OP_RECEIVE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
		send(make_item(aitr_pkg::OP_RECEIVE, 8'hFF, 64'h0, 32'h0));
		send(make_item(aitr_pkg::OP_RECEIVE, 8'hA5, 64'h0123_4567_89AB_CDEF, 32'h0));
		repeat (4) send(make_item(aitr_pkg::OP_NEXT, 8'h00, 64'h0, 32'h0));
		send(make_item(aitr_pkg::OP_TICK, 8'h00, 64'h0, 32'hFFFF_FFFF));
		send(make_item(aitr_pkg::OP_TICK, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFA));
		send(make_item(aitr_pkg::OP_REMOVE, 8'h00, 64'h0, 32'h0));
		send(make_item(aitr_pkg::OP_REMOVE, 8'h00, 64'h0, 32'h0));
		send(make_item(aitr_pkg::OP_NEXT, 8'h00, 64'h0, 32'h0));
		send(make_item(aitr_pkg::OP_RECEIVE, 8'h00, 64'hDEAD_BEEF_CAFE_F00D, 32'h0));
		drain();

		// With every count at the maximum, a new identifier must land in the first slot.
		write_start(aitr_pkg::COUNT_MAX);
		send(make_item(aitr_pkg::OP_RECEIVE, 8'h00, 64'h1, 32'h0));
		send(make_item(aitr_pkg::OP_RECEIVE, 8'hFF, 64'h2, 32'h0));
		send(make_item(aitr_pkg::OP_RECEIVE, 8'hA5, 64'h3, 32'h0));
		for (k = 1; k <= 5; k++)
			send(make_item(aitr_pkg::OP_RECEIVE, 8'(k), 64'(k) << 40, 32'h0));
		send(make_item(aitr_pkg::OP_RECEIVE, 8'h06, 64'h8000_0000_0000_0000, 32'h0));
		drain();

		write_start(16'h0000);
		send(make_item(aitr_pkg::OP_RECEIVE, 8'h77, 64'h7777_0000_7777_0000, 32'h0));
		send(make_item(aitr_pkg::OP_NEXT, 8'h00, 64'h0, 32'h0));
		send(make_item(aitr_pkg::OP_TICK, 8'h00, 64'h0, 32'h0));
		drain();

		for (round = 0; round < 8; round++) begin
			case (round)
				0:       start_value = 16'd1;
				1:       start_value = 16'd65534;
				2:       start_value = 16'd5;
				3:       start_value = 16'($urandom_range(1, 65534));
				4:       start_value = aitr_pkg::COUNT_MAX;
				5:       start_value = 16'd3;
				6:       start_value = 16'd0;
				default: start_value = 16'($urandom_range(2, 12));
			endcase
			write_start(start_value);
			phase = idle_mode_t'(round % 4);
			if (round == 4)
				long_hold_go = 1'b1;
			repeat (240) send(random_item());
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
rtl/aitr_pkg.sv
rtl/aitr_tick_div.sv
rtl/aging_id_table_round_robin_core.sv
rtl/aitr_checker.sv
test/aitr_table_checker.sv
test/tb.sv
